// File: hdl/bts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_pkg
// Shared types and constants of the bilinear texture sampler.
// ----------------------------------------------------------------------------
package bts_pkg;

    localparam int SIDE_BITS  = 9;
    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 16;
    localparam int WT_BITS    = 17;
    localparam int MAG_BITS   = 17;
    localparam int DIV_BITS   = MAG_BITS;
    localparam int AX_LAT     = DIV_BITS + 3;

    typedef logic [1:0] t_wrap;
    localparam t_wrap WRAP_CLAMP  = 2'd0;
    localparam t_wrap WRAP_REPEAT = 2'd1;
    localparam t_wrap WRAP_MIRROR = 2'd2;

    typedef logic [7:0] t_cfg_idx;
    localparam t_cfg_idx CFG_WRAP_H  = 8'd0;
    localparam t_cfg_idx CFG_WRAP_V  = 8'd1;
    localparam t_cfg_idx CFG_WIDTH   = 8'd2;
    localparam t_cfg_idx CFG_HEIGHT  = 8'd3;
    localparam t_cfg_idx CFG_CHANNEL = 8'd4;
    localparam t_cfg_idx CFG_FORMAT  = 8'd5;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [2:0] CH_GRAY = 3'd1;
    localparam logic [2:0] CH_RGB  = 3'd3;
    localparam logic [2:0] CH_RGBA = 3'd4;

    typedef struct packed {
        logic                 clo;
        logic                 chi;
        logic [SIDE_BITS-1:0] fl;
        logic [FRAC_BITS-1:0] frac;
        logic                 neg_a;
        logic                 neg_b;
    } t_ax_side;

endpackage

// File: hdl/bts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module bts_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/bts_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bts_axis
// Pipelined coordinate mapping of one axis: two texel indices and the weight
// of the first, with clamp, repeat or mirrored-repeat addressing.
// ----------------------------------------------------------------------------
module bts_axis (
    input  logic                                 i_clk,
    input  bts_pkg::t_wrap                       i_mode,
    input  logic [bts_pkg::SIDE_BITS-1:0]        i_side,
    input  logic signed [bts_pkg::COORD_BITS-1:0] i_coord,
    output logic [bts_pkg::SIDE_BITS-1:0]        o_idx_a,
    output logic [bts_pkg::SIDE_BITS-1:0]        o_idx_b,
    output logic [bts_pkg::WT_BITS-1:0]          o_weight
);
    import bts_pkg::*;

    logic signed [SIDE_BITS+COORD_BITS:0] r_prod;
    logic signed [SIDE_BITS+COORD_BITS+1:0] p;
    logic signed [18:0] fl;
    logic signed [18:0] fl_b;
    logic signed [18:0] side_m1;
    logic [SIDE_BITS-1:0] sm1;
    t_ax_side n_side;
    logic [18:0] mag_a;
    logic [18:0] mag_b;

    t_ax_side            r_side  [DIV_BITS+1];
    logic [MAG_BITS-1:0] r_mag_a [DIV_BITS+1];
    logic [MAG_BITS-1:0] r_mag_b [DIV_BITS+1];
    logic [SIDE_BITS-1:0] r_rem_a [DIV_BITS+1];
    logic [SIDE_BITS-1:0] r_rem_b [DIV_BITS+1];
    logic                r_q_a   [DIV_BITS+1];
    logic                r_q_b   [DIV_BITS+1];

    logic [SIDE_BITS-1:0] n_idx_a, n_idx_b, r_idx_a, r_idx_b;
    logic [WT_BITS-1:0]   n_weight, r_weight;

    always_ff @(posedge i_clk) begin
        r_prod <= $signed({1'b0, i_side}) * i_coord;
    end

    assign sm1 = i_side - SIDE_BITS'(1);

    always_comb begin
        p        = (SIDE_BITS+COORD_BITS+2)'(r_prod) - 35'sd32768;
        fl       = p[SIDE_BITS+COORD_BITS+1:FRAC_BITS];
        fl_b     = fl + 19'sd1;
        side_m1  = $signed({10'd0, sm1});
        mag_a    = fl[18] ? ~fl : fl;
        mag_b    = fl_b[18] ? ~fl_b : fl_b;
        n_side.clo   = p[SIDE_BITS+COORD_BITS+1] || (p == '0);
        n_side.chi   = (fl >= side_m1);
        n_side.fl    = fl[SIDE_BITS-1:0];
        n_side.frac  = p[FRAC_BITS-1:0];
        n_side.neg_a = fl[18];
        n_side.neg_b = fl_b[18];
    end

    always_ff @(posedge i_clk) begin
        r_side[0]  <= n_side;
        r_mag_a[0] <= mag_a[MAG_BITS-1:0];
        r_mag_b[0] <= mag_b[MAG_BITS-1:0];
        r_rem_a[0] <= '0;
        r_rem_b[0] <= '0;
        r_q_a[0]   <= 1'b0;
        r_q_b[0]   <= 1'b0;
    end

    for (genvar k = 1; k <= DIV_BITS; k++) begin : g_div
        logic [SIDE_BITS:0] t_a;
        logic [SIDE_BITS:0] t_b;
        logic               ge_a;
        logic               ge_b;

        assign t_a  = {r_rem_a[k-1], r_mag_a[k-1][DIV_BITS-k]};
        assign t_b  = {r_rem_b[k-1], r_mag_b[k-1][DIV_BITS-k]};
        assign ge_a = (t_a >= {1'b0, i_side});
        assign ge_b = (t_b >= {1'b0, i_side});

        always_ff @(posedge i_clk) begin
            r_side[k]  <= r_side[k-1];
            r_mag_a[k] <= r_mag_a[k-1];
            r_mag_b[k] <= r_mag_b[k-1];
            r_rem_a[k] <= ge_a ? SIDE_BITS'(t_a - {1'b0, i_side}) : t_a[SIDE_BITS-1:0];
            r_rem_b[k] <= ge_b ? SIDE_BITS'(t_b - {1'b0, i_side}) : t_b[SIDE_BITS-1:0];
            r_q_a[k]   <= ge_a;
            r_q_b[k]   <= ge_b;
        end
    end

    always_comb begin
        n_idx_a  = '0;
        n_idx_b  = '0;
        n_weight = WT_BITS'(17'h10000) - {1'b0, r_side[DIV_BITS].frac};
        unique case (i_mode)
            WRAP_CLAMP: begin
                if (r_side[DIV_BITS].clo) begin
                    n_weight = '0;
                end else if (r_side[DIV_BITS].chi) begin
                    n_idx_a  = sm1;
                    n_idx_b  = sm1;
                    n_weight = '0;
                end else begin
                    n_idx_a = r_side[DIV_BITS].fl;
                    n_idx_b = r_side[DIV_BITS].fl + SIDE_BITS'(1);
                end
            end
            WRAP_REPEAT: begin
                n_idx_a = r_side[DIV_BITS].neg_a ? sm1 - r_rem_a[DIV_BITS] : r_rem_a[DIV_BITS];
                n_idx_b = r_side[DIV_BITS].neg_b ? sm1 - r_rem_b[DIV_BITS] : r_rem_b[DIV_BITS];
            end
            WRAP_MIRROR: begin
                n_idx_a = r_q_a[DIV_BITS] ? sm1 - r_rem_a[DIV_BITS] : r_rem_a[DIV_BITS];
                n_idx_b = r_q_b[DIV_BITS] ? sm1 - r_rem_b[DIV_BITS] : r_rem_b[DIV_BITS];
            end
            default: begin
                n_weight = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_idx_a  <= n_idx_a;
        r_idx_b  <= n_idx_b;
        r_weight <= n_weight;
    end

    assign o_idx_a  = r_idx_a;
    assign o_idx_b  = r_idx_b;
    assign o_weight = r_weight;
endmodule

// File: hdl/bilinear_texture_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_texture_sampler
// Texture unit with four texel memory copies and a bilinear filter pipeline.
// ----------------------------------------------------------------------------
// A transaction is accepted at a rising edge with start high and busy low.
// Busy is high only during reset, so one transaction can enter every cycle.
// A write transaction stores one texel and gives no result. A sample
// transaction gives one result on the output ports, marked by o_result_valid
// for exactly one cycle. A sample passes the restoring remainder pipeline of
// each axis (17 stages), then address, memory read, horizontal blend, vertical
// blend, intensity and output stages. Writes reach the memories at the same
// stage where samples read them, so transactions take effect strictly in
// order. The receiver cannot stall; results are never held. The user must
// write configuration through the cfg channel only while no transaction is in
// flight; the block does not enforce it. Synchronous reset clears the pipeline
// valid bits and the configuration registers to their defaults; the texel
// memories are not cleared and must be written before they are sampled.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler #(
    parameter int TEXEL_DEPTH    = 65536,
    parameter int MAX_SIDE       = 256,
    parameter int COMPONENT_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_operation,
    input  logic [15:0]        i_texel_index,
    input  logic [15:0]        i_texel_red,
    input  logic [15:0]        i_texel_green,
    input  logic [15:0]        i_texel_blue,
    input  logic signed [23:0] i_coord_u,
    input  logic signed [23:0] i_coord_v,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic               o_result_valid,
    output logic [15:0]        o_red_out,
    output logic [15:0]        o_green_out,
    output logic [15:0]        o_blue_out,
    output logic [15:0]        o_intensity_out
);
    import bts_pkg::*;

    localparam int ADDR_W = $clog2(TEXEL_DEPTH);
    localparam int WORD_W = 3 * COMPONENT_BITS;

    typedef struct packed {
        logic        op;
        logic [15:0] idx;
        logic [15:0] red;
        logic [15:0] grn;
        logic [15:0] blu;
    } t_item;

    logic r_busy;
    t_wrap r_wrap_h, r_wrap_v;
    logic [SIDE_BITS-1:0] r_width, r_height;
    logic [2:0] r_chan;
    logic r_fmt;
    logic [SIDE_BITS-1:0] eff_w, eff_h;
    logic accept;

    always_comb begin
        eff_w = r_width;
        if (r_width == '0) begin
            eff_w = SIDE_BITS'(1);
        end else if (32'(r_width) > 32'(MAX_SIDE)) begin
            eff_w = SIDE_BITS'(MAX_SIDE);
        end
        eff_h = r_height;
        if (r_height == '0) begin
            eff_h = SIDE_BITS'(1);
        end else if (32'(r_height) > 32'(MAX_SIDE)) begin
            eff_h = SIDE_BITS'(MAX_SIDE);
        end
    end

    assign accept      = start && !r_busy;
    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_wrap_h <= WRAP_CLAMP;
            r_wrap_v <= WRAP_CLAMP;
            r_width  <= SIDE_BITS'(1);
            r_height <= SIDE_BITS'(1);
            r_chan   <= CH_RGB;
            r_fmt    <= 1'b0;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid && !r_busy) begin
                unique case (i_cfg_index)
                    CFG_WRAP_H:  r_wrap_h <= i_cfg_data[1:0];
                    CFG_WRAP_V:  r_wrap_v <= i_cfg_data[1:0];
                    CFG_WIDTH:   r_width  <= i_cfg_data[SIDE_BITS-1:0];
                    CFG_HEIGHT:  r_height <= i_cfg_data[SIDE_BITS-1:0];
                    CFG_CHANNEL: r_chan   <= i_cfg_data[2:0];
                    CFG_FORMAT:  r_fmt    <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    logic [SIDE_BITS-1:0] i0, i1, j0, j1;
    logic [WT_BITS-1:0]   fi, fj;

    bts_axis u_axis_u (
        .i_clk    (i_clk),
        .i_mode   (r_wrap_h),
        .i_side   (eff_w),
        .i_coord  (i_coord_u),
        .o_idx_a  (i0),
        .o_idx_b  (i1),
        .o_weight (fi)
    );

    bts_axis u_axis_v (
        .i_clk    (i_clk),
        .i_mode   (r_wrap_v),
        .i_side   (eff_h),
        .i_coord  (i_coord_v),
        .o_idx_a  (j0),
        .o_idx_b  (j1),
        .o_weight (fj)
    );

    logic  r_dl_vld [AX_LAT];
    t_item r_dl     [AX_LAT];

    always_ff @(posedge i_clk) begin
        r_dl[0] <= '{op: i_operation, idx: i_texel_index, red: i_texel_red,
                     grn: i_texel_green, blu: i_texel_blue};
        for (int k = 1; k < AX_LAT; k++) begin
            r_dl[k] <= r_dl[k-1];
        end
        if (!i_rst_n) begin
            for (int k = 0; k < AX_LAT; k++) begin
                r_dl_vld[k] <= 1'b0;
            end
        end else begin
            r_dl_vld[0] <= accept;
            for (int k = 1; k < AX_LAT; k++) begin
                r_dl_vld[k] <= r_dl_vld[k-1];
            end
        end
    end

    // Neighbor order: (i0,j0), (i1,j0), (i0,j1), (i1,j1).
    logic [SIDE_BITS-1:0] col [4];
    logic [SIDE_BITS-1:0] row [4];
    logic [20:0] n_addr [4];
    logic [20:0] r_a_addr [4];
    logic r_a_vld;
    t_item r_a_item;
    logic [WT_BITS-1:0] r_a_wx, r_a_wy;

    assign col[0] = i0;
    assign col[1] = i1;
    assign col[2] = i0;
    assign col[3] = i1;
    assign row[0] = j0;
    assign row[1] = j0;
    assign row[2] = j1;
    assign row[3] = j1;

    for (genvar k = 0; k < 4; k++) begin : g_addr
        logic [2*SIDE_BITS-1:0] rprod;
        assign rprod     = row[k] * eff_w;
        assign n_addr[k] = 21'(rprod) + 21'(col[k]);
    end

    always_ff @(posedge i_clk) begin
        r_a_item <= r_dl[AX_LAT-1];
        r_a_wx   <= fi;
        r_a_wy   <= fj;
        for (int k = 0; k < 4; k++) begin
            r_a_addr[k] <= n_addr[k];
        end
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= r_dl_vld[AX_LAT-1];
        end
    end

    logic we;
    logic [20:0] widx;
    logic [WORD_W-1:0] wdata;
    logic [WORD_W-1:0] rdata [4];
    logic r_m_vld;
    logic r_m_oob [4];
    logic [WT_BITS-1:0] r_m_wx, r_m_wy;

    assign widx  = 21'(r_a_item.idx);
    assign we    = r_a_vld && (r_a_item.op == OP_WRITE) && (widx < 21'(TEXEL_DEPTH));
    assign wdata = {r_a_item.blu[COMPONENT_BITS-1:0], r_a_item.grn[COMPONENT_BITS-1:0],
                    r_a_item.red[COMPONENT_BITS-1:0]};

    for (genvar k = 0; k < 4; k++) begin : g_ram
        bts_ram #(
            .WIDTH (WORD_W),
            .DEPTH (TEXEL_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (widx[ADDR_W-1:0]),
            .i_wdata (wdata),
            .i_raddr (r_a_addr[k][ADDR_W-1:0]),
            .o_rdata (rdata[k])
        );
    end

    always_ff @(posedge i_clk) begin
        r_m_wx <= r_a_wx;
        r_m_wy <= r_a_wy;
        for (int k = 0; k < 4; k++) begin
            r_m_oob[k] <= (r_a_addr[k] >= 21'(TEXEL_DEPTH));
        end
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else begin
            r_m_vld <= r_a_vld && (r_a_item.op == OP_SAMPLE);
        end
    end

    logic [16:0] norm [4][3];
    logic [32:0] n_h_top [3];
    logic [32:0] n_h_bot [3];
    logic [32:0] r_h_top [3];
    logic [32:0] r_h_bot [3];
    logic [WT_BITS-1:0] wx_c;
    logic [WT_BITS-1:0] r_h_wy;
    logic r_h_vld;

    assign wx_c = WT_BITS'(17'h10000) - r_m_wx;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            for (int c = 0; c < 3; c++) begin
                logic [15:0] v;
                v = r_m_oob[k] ? 16'd0 : 16'(rdata[k][c*COMPONENT_BITS +: COMPONENT_BITS]);
                if (r_fmt) begin
                    norm[k][c] = {1'b0, v} + 17'(v[15]);
                end else begin
                    norm[k][c] = {1'b0, v[7:0], v[7:0]} + 17'(v[7]);
                end
            end
        end
        for (int c = 0; c < 3; c++) begin
            n_h_top[c] = 33'(norm[0][c] * r_m_wx) + 33'(norm[1][c] * wx_c);
            n_h_bot[c] = 33'(norm[2][c] * r_m_wx) + 33'(norm[3][c] * wx_c);
        end
    end

    always_ff @(posedge i_clk) begin
        r_h_wy <= r_m_wy;
        for (int c = 0; c < 3; c++) begin
            r_h_top[c] <= n_h_top[c];
            r_h_bot[c] <= n_h_bot[c];
        end
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else begin
            r_h_vld <= r_m_vld;
        end
    end

    logic [WT_BITS-1:0] wy_c;
    logic [48:0] blend [3];
    logic [16:0] r_v_val [3];
    logic r_v_vld;

    assign wy_c = WT_BITS'(17'h10000) - r_h_wy;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            blend[c] = 49'(r_h_top[c] * r_h_wy) + 49'(r_h_bot[c] * wy_c) + 49'h80000000;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_v_val[c] <= blend[c][48:32];
        end
        if (!i_rst_n) begin
            r_v_vld <= 1'b0;
        end else begin
            r_v_vld <= r_h_vld;
        end
    end

    // Division by three through a reciprocal, exact below 2^19.
    logic [17:0] isum;
    logic [35:0] iprod;
    logic [16:0] r_i_val [3];
    logic [16:0] r_i_third;
    logic r_i_vld;

    assign isum  = 18'(r_v_val[0]) + 18'(r_v_val[1]) + 18'(r_v_val[2]) + 18'd1;
    assign iprod = isum * 36'd174763;

    always_ff @(posedge i_clk) begin
        r_i_third <= iprod[35:19];
        for (int c = 0; c < 3; c++) begin
            r_i_val[c] <= r_v_val[c];
        end
        if (!i_rst_n) begin
            r_i_vld <= 1'b0;
        end else begin
            r_i_vld <= r_v_vld;
        end
    end

    function automatic logic [15:0] sat16(input logic [16:0] v);
        return v[16] ? 16'hFFFF : v[15:0];
    endfunction

    logic [15:0] n_red, n_grn, n_blu, n_int;
    logic [15:0] r_red, r_grn, r_blu, r_int;
    logic r_o_vld;

    always_comb begin
        n_red = '0;
        n_grn = '0;
        n_blu = '0;
        n_int = '0;
        case (r_chan) inside
            CH_GRAY: begin
                n_red = sat16(r_i_val[0]);
                n_grn = n_red;
                n_blu = n_red;
                n_int = n_red;
            end
            CH_RGB, CH_RGBA: begin
                n_red = sat16(r_i_val[0]);
                n_grn = sat16(r_i_val[1]);
                n_blu = sat16(r_i_val[2]);
                n_int = sat16(r_i_third);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_red <= n_red;
        r_grn <= n_grn;
        r_blu <= n_blu;
        r_int <= n_int;
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_i_vld;
        end
    end

    assign o_result_valid  = r_o_vld;
    assign o_red_out       = r_red;
    assign o_green_out     = r_grn;
    assign o_blue_out      = r_blu;
    assign o_intensity_out = r_int;
endmodule
